// File: sv/freq_table_interpolator_macros.svh
// ---------------------------------------------------------------------------
// freq_table_interpolator assertion macros
// concurrent check helpers, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef FREQ_TABLE_INTERPOLATOR_MACROS_SVH
`define FREQ_TABLE_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define FTI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FTI_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define FTI_ASSERT(label, prop, msg)
`define FTI_NEVER(label, expr, msg)
`endif

`endif

// File: sv/fti_pkg.sv
// ---------------------------------------------------------------------------
// fti_pkg
// types and codes of the frequency table interpolator
// ---------------------------------------------------------------------------
package fti_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BELOW = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        point_freq;
      logic signed [31:0] point_amp;
      logic signed [31:0] point_phase;
      logic               use_default;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] amp_out;
      logic signed [31:0] phase_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0] freq;
      logic [31:0] amp;
      logic [31:0] phase;
   } ent_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_WALK,
      S_MUL0,
      S_MUL1,
      S_SUM,
      S_DIV,
      S_NEXT,
      S_FIN
   } state_type;

endpackage

// File: sv/freq_table_interpolator.sv
// ---------------------------------------------------------------------------
// freq_table_interpolator
// point table with linear interpolation of amplitude and phase
// ---------------------------------------------------------------------------
// Append, clear, default and empty-table requests are answered directly from
// the idle state. A query reads the first and last points, then, if it lies
// within them, walks the table one entry a cycle through the single read port
// of the point memory up to the bracketing point, and an interpolated query
// adds two blends, of amplitude and then phase, each a pair of products, their
// sum and a bit-serial 33-step divide. The memory has no clearing pass; a clear
// only zeroes the point count.
`include "freq_table_interpolator_macros.svh"

module freq_table_interpolator #(
   parameter int TABLE_DEPTH = fti_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fti_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fti_pkg::rsp_type rsp_payload
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   fti_pkg::ent_type mem [TABLE_DEPTH];
   fti_pkg::ent_type rd_ff;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;

   fti_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   fti_pkg::req_type   q_ff, q_in;
   fti_pkg::ent_type   prev_ff, prev_in, lo_ff, lo_in, hi_ff, hi_in;
   logic               sel_ff, sel_in;
   logic signed [64:0] p0_ff, p0_in, p1_ff, p1_in;
   logic               neg_ff, neg_in;
   logic [32:0]        rem_ff, rem_in;
   logic [32:0]        dvd_ff, dvd_in;
   logic [32:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [31:0]        amp_ff, amp_in;
   fti_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               out_free, req_fire;
   logic               walk_over, query_go, div_bad;
   logic [CW-1:0]      last_c;
   logic [31:0]        span, w0, w1, v0, v1, res;
   logic signed [65:0] sum;
   logic [65:0]        mag, dividend;
   logic [33:0]        trial;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == fti_pkg::S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign last_c    = count_ff - CW'(1);

   assign span  = hi_ff.freq - lo_ff.freq;
   assign w0    = hi_ff.freq - q_ff.point_freq;
   assign w1    = q_ff.point_freq - lo_ff.freq;
   assign v0    = sel_ff ? lo_ff.phase : lo_ff.amp;
   assign v1    = sel_ff ? hi_ff.phase : hi_ff.amp;
   assign sum   = {p0_ff[64], p0_ff} + {p1_ff[64], p1_ff};
   assign mag   = sum[65] ? 66'(-sum) : 66'(sum);
   assign dividend = mag + {35'd0, span[31:1]};
   assign trial = {rem_ff, dvd_ff[32]};
   assign res   = neg_ff ? 32'(-quo_ff) : quo_ff[31:0];

   assign walk_over = (state_ff == fti_pkg::S_WALK)
                      && ({1'b0, idx_ff} >= (AW+1)'(count_ff));
   assign query_go  = req_fire && (req_payload.cmd == fti_pkg::CMD_QUERY)
                      && !req_payload.use_default && (count_ff != '0);
   assign div_bad   = (state_ff == fti_pkg::S_DIV) && (rem_ff >= {1'b0, span});

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= '{req_payload.point_freq, req_payload.point_amp,
                                    req_payload.point_phase};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fti_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      q_ff    <= q_in;
      prev_ff <= prev_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      sel_ff  <= sel_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      amp_ff  <= amp_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sel_in       = sel_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      amp_in       = amp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      mem_we       = 1'b0;
      unique case (state_ff)
         fti_pkg::S_IDLE: begin
            if (req_fire) begin
               q_in = req_payload;
               rsp_in = '{fti_pkg::ST_OK, 32'sd0, 32'sd0};
               rsp_valid_in = 1'b1;
               unique case (req_payload.cmd)
                  fti_pkg::CMD_APPEND: begin
                     if (count_ff >= DEPTH_C) begin
                        rsp_in.status = fti_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  fti_pkg::CMD_CLEAR: count_in = '0;
                  fti_pkg::CMD_QUERY: begin
                     if (req_payload.use_default) begin
                        rsp_in.amp_out = fti_pkg::ONE_Q16;
                     end else if (count_ff == '0) begin
                        rsp_in.status = fti_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        state_in = fti_pkg::S_FIRST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         fti_pkg::S_FIRST: begin
            if (q_ff.point_freq < rd_ff.freq) begin
               rsp_in = '{fti_pkg::ST_BELOW, 32'sd0, 32'sd0};
               state_in = fti_pkg::S_FIN;
            end else begin
               rd_addr = last_c[AW-1:0];
               state_in = fti_pkg::S_LAST;
            end
         end
         fti_pkg::S_LAST: begin
            if (q_ff.point_freq > rd_ff.freq) begin
               rsp_in = '{fti_pkg::ST_OK, rd_ff.amp, rd_ff.phase};
               state_in = fti_pkg::S_FIN;
            end else begin
               rd_addr = '0;
               idx_in = '0;
               state_in = fti_pkg::S_WALK;
            end
         end
         fti_pkg::S_WALK: begin
            if (q_ff.point_freq == rd_ff.freq) begin
               rsp_in = '{fti_pkg::ST_OK, rd_ff.amp, rd_ff.phase};
               state_in = fti_pkg::S_FIN;
            end else if (q_ff.point_freq < rd_ff.freq) begin
               lo_in = prev_ff;
               hi_in = rd_ff;
               sel_in = 1'b0;
               state_in = fti_pkg::S_MUL0;
            end else begin
               prev_in = rd_ff;
               idx_in = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         fti_pkg::S_MUL0: begin
            p0_in = $signed({1'b0, w0}) * $signed(v0);
            state_in = fti_pkg::S_MUL1;
         end
         fti_pkg::S_MUL1: begin
            p1_in = $signed({1'b0, w1}) * $signed(v1);
            state_in = fti_pkg::S_SUM;
         end
         fti_pkg::S_SUM: begin
            // quotient fits 33 bits since |n| stays below 2^31 * d
            neg_in = sum[65];
            rem_in = dividend[65:33];
            dvd_in = dividend[32:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = fti_pkg::S_DIV;
         end
         fti_pkg::S_DIV: begin
            if (trial >= {2'b00, span}) begin
               rem_in = 33'(trial - {2'b00, span});
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[31:0], 1'b0};
            end
            dvd_in = {dvd_ff[31:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               state_in = fti_pkg::S_NEXT;
            end
         end
         fti_pkg::S_NEXT: begin
            if (!sel_ff) begin
               amp_in = res;
               sel_in = 1'b1;
               state_in = fti_pkg::S_MUL0;
            end else begin
               rsp_in = '{fti_pkg::ST_OK, amp_ff, res};
               state_in = fti_pkg::S_FIN;
            end
         end
         fti_pkg::S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in = fti_pkg::S_IDLE;
            end
         end
         default: state_in = fti_pkg::S_IDLE;
      endcase
   end

   `FTI_NEVER(a_count_bound, count_ff > DEPTH_C, "point count above table depth")
   `FTI_NEVER(a_walk_bound, walk_over, "walk past last point")
   `FTI_NEVER(a_div_rem, div_bad, "divider remainder not below divisor")
   `FTI_ASSERT(a_query_start, query_go |=> state_ff == fti_pkg::S_FIRST, "query did not start walk")

endmodule
